[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that the consequence holds in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[rtl/core/slcu_pkg.sv]
// Package: operation codes and lane conversion functions.
`default_nettype none
package slcu_pkg;
	typedef enum logic [2:0] {
		OP_NARROW16 = 3'd0,
		OP_NARROW32 = 3'd1,
		OP_WIDEN8   = 3'd2,
		OP_WIDEN16  = 3'd3,
		OP_TRUNCSAT = 3'd4,
		OP_CONVERT  = 3'd5
	} op_t;

	// Saturate a signed 16-bit lane to 8 bits, signed or unsigned as sgn selects.
	function automatic logic [7:0] sat16to8(input logic [15:0] x, input logic sgn);
		logic [7:0] r;
		if (sgn) begin
			if (!x[15] && x[14:7] != 8'h00) r = 8'h7f;
			else if (x[15] && x[14:7] != 8'hff) r = 8'h80;
			else r = x[7:0];
		end else begin
			if (x[15]) r = 8'h00;
			else if (x[14:8] != 7'h00) r = 8'hff;
			else r = x[7:0];
		end
		return r;
	endfunction

	// Saturate a signed 32-bit lane to 16 bits, signed or unsigned as sgn selects.
	function automatic logic [15:0] sat32to16(input logic [31:0] x, input logic sgn);
		logic [15:0] r;
		if (sgn) begin
			if (!x[31] && x[30:15] != 16'h0000) r = 16'h7fff;
			else if (x[31] && x[30:15] != 16'hffff) r = 16'h8000;
			else r = x[15:0];
		end else begin
			if (x[31]) r = 16'h0000;
			else if (x[30:16] != 15'h0000) r = 16'hffff;
			else r = x[15:0];
		end
		return r;
	endfunction

	// Truncate f32 toward zero with saturation; NaN gives zero.
	function automatic logic [31:0] trunc_sat(input logic [31:0] f, input logic sgn);
		logic        neg;
		logic [7:0]  e;
		logic [22:0] m;
		logic [31:0] mag;
		logic [31:0] r;
		neg = f[31];
		e   = f[30:23];
		m   = f[22:0];
		mag = {8'h00, 1'b1, m};
		if (e >= 8'd150) mag = mag << (e - 8'd150);
		else mag = mag >> (8'd150 - e);
		if (e == 8'hff && m != 23'd0) r = 32'h0;
		else if (sgn && e >= 8'd158) r = neg ? 32'h80000000 : 32'h7fffffff;
		else if (!sgn && neg) r = 32'h0;
		else if (!sgn && e >= 8'd159) r = 32'hffffffff;
		else if (e < 8'd127) r = 32'h0;
		else if (sgn && neg) r = 32'h0 - mag;
		else r = mag;
		return r;
	endfunction

	// Convert i32/u32 to f32, round to nearest even.
	function automatic logic [31:0] int_to_float(input logic [31:0] x, input logic sgn);
		logic        neg;
		logic [31:0] mag;
		logic [4:0]  p;
		logic [31:0] norm;
		logic [24:0] keep;
		logic        rnd;
		logic        sticky;
		logic [7:0]  ex;
		neg = sgn & x[31];
		mag = neg ? 32'h0 - x : x;
		p = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (mag[i]) p = 5'(i);
		end
		norm   = mag << (5'd31 - p);
		rnd    = norm[7];
		sticky = norm[6:0] != 7'd0;
		keep   = {1'b0, norm[31:8]};
		if (rnd && (sticky || norm[8])) keep = keep + 25'd1;
		ex = 8'(p) + 8'd127;
		if (keep[24]) begin
			keep = keep >> 1;
			ex   = ex + 8'd1;
		end
		return (mag == 32'h0) ? 32'h0 : {neg, ex, keep[22:0]};
	endfunction
endpackage
`default_nettype wire

[rtl/core/simd_lane_conversion_unit.sv]
// Top level: SIMD lane conversion unit with input and result registers.
//  channel | direction | handshake           | payload
//  input   | in        | in_valid/in_stall   | operation, signed_mode, low_half, first_*, second_*
//  result  | out       | out_valid/out_stall | result_low, result_high
// An item passes through the input register and then the result register;
// one transaction per cycle is sustained while out_stall is low.
// The input register advances whenever the result register can take its item.
// A stall holds a valid result, and the input register when full; in_stall follows from it.
// Reset (arst_n low) clears both valid bits; payload registers are not reset.
`default_nettype none
module simd_lane_conversion_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic        signed_mode,
	input  wire logic        low_half,
	input  wire logic [63:0] first_low,
	input  wire logic [63:0] first_high,
	input  wire logic [63:0] second_low,
	input  wire logic [63:0] second_high,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] result_low,
	output logic      [63:0] result_high
);
	import slcu_pkg::*;
`include "assert_macros.svh"

	logic         vld_s1, vld_s2;
	logic [2:0]   op_s1;
	logic         sgn_s1, low_s1;
	logic [127:0] a_s1, b_s1, res_comb, res_s2;
	logic         adv_s2, adv_s1;

	// Result stage takes a new item when empty or when its item leaves.
	assign adv_s2   = !vld_s2 || !out_stall;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= in_valid;
			if (adv_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1  <= operation;
			sgn_s1 <= signed_mode;
			low_s1 <= low_half;
			a_s1   <= {first_high, first_low};
			b_s1   <= {second_high, second_low};
		end
		if (adv_s2 && vld_s1) res_s2 <= res_comb;
	end

	slcu_datapath u_dp (
		.operation   (op_s1),
		.signed_mode (sgn_s1),
		.low_half    (low_s1),
		.first       (a_s1),
		.second      (b_s1),
		.result      (res_comb)
	);

	assign out_valid   = vld_s2;
	assign result_low  = res_s2[63:0];
	assign result_high = res_s2[127:64];

	// A stalled result must stay valid and hold its data.
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(res_s2), "result lost under stall")
	// A full pipeline under stall must refuse input.
	`CHK_IMPL(a_full, clk, arst_n, vld_s1 && vld_s2 && out_stall, in_stall, "input taken while full")
	// Accepted input reaches stage one.
	`CHK_NEXT(a_take, clk, arst_n, in_valid && !in_stall, vld_s1, "accepted item dropped")
endmodule
`default_nettype wire

[rtl/core/slcu_datapath.sv]
// Datapath: one-pass lane conversion from source vectors to result vector.
`default_nettype none
module slcu_datapath (
	input  wire logic [2:0]   operation,
	input  wire logic         signed_mode,
	input  wire logic         low_half,
	input  wire logic [127:0] first,
	input  wire logic [127:0] second,
	output logic      [127:0] result
);
	import slcu_pkg::*;

	logic [127:0] nar8, nar16, wid8, wid16, trn, cvt;
	logic [63:0]  half;

	assign half = low_half ? first[63:0] : first[127:64];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			nar8[8*i +: 8]      = sat16to8(first[16*i +: 16], signed_mode);
			nar8[64+8*i +: 8]   = sat16to8(second[16*i +: 16], signed_mode);
			wid8[16*i +: 16]    = {{8{signed_mode & half[8*i+7]}}, half[8*i +: 8]};
		end
		for (int i = 0; i < 4; i++) begin
			nar16[16*i +: 16]    = sat32to16(first[32*i +: 32], signed_mode);
			nar16[64+16*i +: 16] = sat32to16(second[32*i +: 32], signed_mode);
			wid16[32*i +: 32]    = {{16{signed_mode & half[16*i+15]}}, half[16*i +: 16]};
			trn[32*i +: 32]      = trunc_sat(first[32*i +: 32], signed_mode);
			cvt[32*i +: 32]      = int_to_float(first[32*i +: 32], signed_mode);
		end
	end

	always_comb begin
		case (operation)
			OP_NARROW16: result = nar8;
			OP_NARROW32: result = nar16;
			OP_WIDEN8:   result = wid8;
			OP_WIDEN16:  result = wid16;
			OP_TRUNCSAT: result = trn;
			OP_CONVERT:  result = cvt;
			default:     result = 128'h0;
		endcase
	end
endmodule
`default_nettype wire
